>>> sv/sbcd_pkg.sv
// Shared types and constants for the sphere boundary crossing detector.
package sbcd_pkg;

    localparam int COORD_WIDTH   = 32;
    localparam int FRACTION_BITS = 16;
    localparam int RADIUS_W      = 32;
    localparam int FRAC_FIELD_W  = 17;

    localparam logic [1:0] ST_NONE      = 2'd0;
    localparam logic [1:0] ST_CROSS     = 2'd1;
    localparam logic [1:0] ST_MALFORMED = 2'd2;

    typedef struct packed {
        logic signed [31:0] before_x;
        logic signed [31:0] before_y;
        logic signed [31:0] before_z;
        logic signed [31:0] after_x;
        logic signed [31:0] after_y;
        logic signed [31:0] after_z;
    } t_in;

    typedef struct packed {
        logic [1:0]              status;
        logic [FRAC_FIELD_W-1:0] crossing_fraction;
    } t_out;

endpackage

>>> sv/sphere_boundary_crossing_detect_unit.sv
// Top level of the sphere boundary crossing detector.
// Accepts one item per cycle unless the output stalls, and returns one result per item:
// three stages form the squared lengths, the square root takes one stage per root bit,
// the divide one stage per fraction bit. A stall on the output freezes the whole
// pipeline; the radius may only be written while no item is in flight.
module sphere_boundary_crossing_detect_unit #(
    parameter int COORD_WIDTH   = sbcd_pkg::COORD_WIDTH,
    parameter int FRACTION_BITS = sbcd_pkg::FRACTION_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  sbcd_pkg::t_in                 i_item,
    output logic                          o_valid,
    input  logic                          i_stall,
    output sbcd_pkg::t_out                o_item,
    input  logic                          i_cfg_wr_en,
    input  logic [sbcd_pkg::RADIUS_W-1:0] i_cfg_data
);

    logic                          w_en;
    logic                          w_v0, w_v1;
    logic [COORD_WIDTH-1:0]        w_r0, w_r1;
    logic [sbcd_pkg::RADIUS_W-1:0] r_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= '0;
        end else if (i_cfg_wr_en) begin
            r_radius <= i_cfg_data;
        end
    end

    assign w_en    = !(o_valid && i_stall);
    assign o_stall = o_valid && i_stall;

    sbcd_len #(.CW(COORD_WIDTH)) u_len0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_x     (i_item.before_x[COORD_WIDTH-1:0]),
        .i_y     (i_item.before_y[COORD_WIDTH-1:0]),
        .i_z     (i_item.before_z[COORD_WIDTH-1:0]),
        .o_valid (w_v0),
        .o_len   (w_r0)
    );

    sbcd_len #(.CW(COORD_WIDTH)) u_len1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_x     (i_item.after_x[COORD_WIDTH-1:0]),
        .i_y     (i_item.after_y[COORD_WIDTH-1:0]),
        .i_z     (i_item.after_z[COORD_WIDTH-1:0]),
        .o_valid (w_v1),
        .o_len   (w_r1)
    );

    sbcd_frac #(.CW(COORD_WIDTH), .FB(FRACTION_BITS)) u_frac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_v0 && w_v1),
        .i_r0     (w_r0),
        .i_r1     (w_r1),
        .i_radius (r_radius),
        .o_valid  (o_valid),
        .o_item   (o_item)
    );

`ifndef ASSERT_OFF
    a_len_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_v0 == w_v1)
        else $error("length pipelines out of step");

    a_no_cross_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_item.status == sbcd_pkg::ST_NONE ||
                    o_item.status == sbcd_pkg::ST_MALFORMED)
        |-> o_item.crossing_fraction == '0)
        else $error("nonzero fraction without crossing");

    a_malformed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !$past(i_cfg_wr_en)
        |-> ((o_item.status == sbcd_pkg::ST_MALFORMED) == (r_radius == '0)))
        else $error("malformed status does not match radius");
`endif

endmodule

>>> sv/sbcd_isqrt.sv
// Pipelined floor square root, one result bit per stage.
module sbcd_isqrt #(
    parameter int CW = sbcd_pkg::COORD_WIDTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [2*CW-1:0] i_sq,
    output logic            o_valid,
    output logic [CW-1:0]   o_root
);

    localparam int RW = CW + 2;

    logic [2*CW-1:0] r_val  [0:CW];
    logic [RW-1:0]   r_rem  [0:CW];
    logic [CW-1:0]   r_root [0:CW];
    logic            r_v    [0:CW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_val[0]  <= i_sq;
            r_rem[0]  <= '0;
            r_root[0] <= '0;
        end
    end

    for (genvar k = 0; k < CW; k++) begin : g_step
        logic [RW:0] n_trial;
        logic [RW:0] n_sub;
        logic [RW:0] n_cmp;
        logic        n_ge;

        // remainder stays below 2^(CW+1), so its top bit is always clear
        always_comb begin
            n_trial = {r_rem[k][RW-2:0], r_val[k][2*CW-1 -: 2]};
            n_cmp   = {1'b0, r_root[k], 2'b01};
            n_ge    = (n_trial >= n_cmp);
            n_sub   = n_trial - n_cmp;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_val[k+1]  <= r_val[k] << 2;
                r_rem[k+1]  <= n_ge ? n_sub[RW-1:0] : n_trial[RW-1:0];
                r_root[k+1] <= {r_root[k][CW-2:0], n_ge};
            end
        end
    end

    assign o_valid = r_v[CW];
    assign o_root  = r_root[CW];

endmodule

>>> sv/sbcd_len.sv
// Vector length: magnitude, square, sum and square root stages.
module sbcd_len #(
    parameter int CW = sbcd_pkg::COORD_WIDTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [CW-1:0] i_x,
    input  logic [CW-1:0] i_y,
    input  logic [CW-1:0] i_z,
    output logic          o_valid,
    output logic [CW-1:0] o_len
);

    logic [CW-1:0]   n_mag [0:2];
    logic [CW-1:0]   r_mag [0:2];
    logic [2*CW-1:0] r_sq  [0:2];
    logic [2*CW-1:0] r_sum;
    logic            r_v_mag;
    logic            r_v_sq;
    logic            r_v_sum;

    always_comb begin
        n_mag[0] = i_x[CW-1] ? (~i_x + 1'b1) : i_x;
        n_mag[1] = i_y[CW-1] ? (~i_y + 1'b1) : i_y;
        n_mag[2] = i_z[CW-1] ? (~i_z + 1'b1) : i_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_mag <= 1'b0;
            r_v_sq  <= 1'b0;
            r_v_sum <= 1'b0;
        end else if (i_en) begin
            r_v_mag <= i_valid;
            r_v_sq  <= r_v_mag;
            r_v_sum <= r_v_sq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_mag[i] <= n_mag[i];
                r_sq[i]  <= (2*CW)'(r_mag[i]) * (2*CW)'(r_mag[i]);
            end
            r_sum <= r_sq[0] + r_sq[1] + r_sq[2];
        end
    end

    sbcd_isqrt #(.CW(CW)) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r_v_sum),
        .i_sq    (r_sum),
        .o_valid (o_valid),
        .o_root  (o_len)
    );

endmodule

>>> sv/sbcd_frac.sv
// Radius compare, pipelined fraction divide and output register.
module sbcd_frac #(
    parameter int CW = sbcd_pkg::COORD_WIDTH,
    parameter int FB = sbcd_pkg::FRACTION_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic [CW-1:0]                  i_r0,
    input  logic [CW-1:0]                  i_r1,
    input  logic [sbcd_pkg::RADIUS_W-1:0]  i_radius,
    output logic                           o_valid,
    output sbcd_pkg::t_out                 o_item
);

    localparam int DW = sbcd_pkg::RADIUS_W;

    logic [DW-1:0] n_r0, n_r1, n_num, n_den;
    logic [1:0]    n_status;

    logic [DW-1:0] r_rem    [0:FB];
    logic [FB-1:0] r_q      [0:FB];
    logic [DW-1:0] r_den    [0:FB];
    logic [1:0]    r_status [0:FB];
    logic          r_dz     [0:FB];
    logic          r_ovf    [0:FB];
    logic          r_v      [0:FB];

    logic [FB:0]   n_frac;
    logic          r_ov;
    sbcd_pkg::t_out r_out;

    always_comb begin
        n_r0     = DW'(i_r0);
        n_r1     = DW'(i_r1);
        n_num    = '0;
        n_den    = '0;
        n_status = sbcd_pkg::ST_NONE;
        if (i_radius == '0) begin
            n_status = sbcd_pkg::ST_MALFORMED;
        end else if (n_r0 < i_radius && n_r1 > i_radius) begin
            n_status = sbcd_pkg::ST_CROSS;
            n_num    = i_radius - n_r0;
            n_den    = n_r1 - n_r0;
        end else if (n_r0 > i_radius && n_r1 < i_radius) begin
            n_status = sbcd_pkg::ST_CROSS;
            n_num    = n_r0 - i_radius;
            n_den    = n_r0 - n_r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]    <= n_num;
            r_q[0]      <= '0;
            r_den[0]    <= n_den;
            r_status[0] <= n_status;
            r_dz[0]     <= (n_den == '0);
            r_ovf[0]    <= (n_num >= n_den);
        end
    end

    for (genvar k = 0; k < FB; k++) begin : g_div
        logic [DW:0] n_shift;
        logic [DW:0] n_sub;
        logic        n_ge;

        always_comb begin
            n_shift = {r_rem[k], 1'b0};
            n_ge    = (n_shift >= {1'b0, r_den[k]});
            n_sub   = n_shift - {1'b0, r_den[k]};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]    <= n_ge ? n_sub[DW-1:0] : n_shift[DW-1:0];
                r_q[k+1]      <= {r_q[k][FB-2:0], n_ge};
                r_den[k+1]    <= r_den[k];
                r_status[k+1] <= r_status[k];
                r_dz[k+1]     <= r_dz[k];
                r_ovf[k+1]    <= r_ovf[k];
            end
        end
    end

    always_comb begin
        if (r_status[FB] != sbcd_pkg::ST_CROSS) begin
            n_frac = '0;
        end else if (r_dz[FB]) begin
            n_frac = (FB+1)'(1) << (FB - 1);
        end else if (r_ovf[FB]) begin
            n_frac = (FB+1)'(1) << FB;
        end else begin
            n_frac = {1'b0, r_q[FB]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_ov <= r_v[FB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out.status            <= r_status[FB];
            r_out.crossing_fraction <= sbcd_pkg::FRAC_FIELD_W'(n_frac);
        end
    end

    assign o_valid = r_ov;
    assign o_item  = r_out;

endmodule

>>> bench/testbench.sv
// Testbench for the sphere boundary crossing detector with a scoreboard.
`timescale 1ns / 100ps

class crossing_scoreboard;
    sbcd_pkg::t_out pending_results[$];
    logic [31:0]    radius;
    int             mismatches;

    function new();
        radius = '0;
        mismatches = 0;
    endfunction

    static function logic [63:0] magnitude(logic signed [31:0] c);
        logic [63:0] v;
        v = {{32{c[31]}}, c};
        if (c[31]) v = -v;
        return v;
    endfunction

    static function logic [63:0] floor_sqrt(logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] bitv;
        rem = v;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    static function logic [63:0] distance(logic signed [31:0] x, logic signed [31:0] y,
                                          logic signed [31:0] z);
        logic [63:0] mx, my, mz;
        mx = magnitude(x);
        my = magnitude(y);
        mz = magnitude(z);
        return floor_sqrt(mx * mx + my * my + mz * mz);
    endfunction

    function sbcd_pkg::t_out crossing_of(sbcd_pkg::t_in it);
        sbcd_pkg::t_out res;
        logic [63:0] r0, r1, rad, num, den, frac;
        res = '0;
        if (radius == 0) begin
            res.status = sbcd_pkg::ST_MALFORMED;
            return res;
        end
        rad = {32'd0, radius};
        r0 = distance(it.before_x, it.before_y, it.before_z);
        r1 = distance(it.after_x, it.after_y, it.after_z);
        if ((r0 >= rad && r1 >= rad) || (r0 <= rad && r1 <= rad)) begin
            res.status = sbcd_pkg::ST_NONE;
            return res;
        end
        if (r0 < rad) begin
            num = rad - r0;
            den = r1 - r0;
        end else begin
            num = r0 - rad;
            den = r0 - r1;
        end
        if (den == 0) begin
            frac = 64'd1 << (sbcd_pkg::FRACTION_BITS - 1);
        end else begin
            frac = (num << sbcd_pkg::FRACTION_BITS) / den;
            if (frac > (64'd1 << sbcd_pkg::FRACTION_BITS))
                frac = 64'd1 << sbcd_pkg::FRACTION_BITS;
        end
        res.status = sbcd_pkg::ST_CROSS;
        res.crossing_fraction = frac[sbcd_pkg::FRAC_FIELD_W-1:0];
        return res;
    endfunction

    function void note_item(sbcd_pkg::t_in it);
        pending_results.push_back(crossing_of(it));
    endfunction

    task report(string msg);
        $display("mismatch: %s", msg);
        mismatches++;
    endtask

    task check_result(sbcd_pkg::t_out got);
        sbcd_pkg::t_out want;
        if (pending_results.size() == 0) begin
            report($sformatf("unexpected result %p", got));
        end else begin
            want = pending_results.pop_front();
            if (got.status !== want.status)
                report($sformatf("status got %0d want %0d", got.status, want.status));
            if (got.crossing_fraction !== want.crossing_fraction)
                report($sformatf("fraction got %0d want %0d",
                                 got.crossing_fraction, want.crossing_fraction));
        end
    endtask
endclass

module testbench;

    localparam int LATENCY = 54;
    localparam longint CYCLE_LIMIT = 2000000;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_valid;
    logic  o_stall;
    sbcd_pkg::t_in   i_item;
    logic  o_valid;
    logic  i_stall;
    sbcd_pkg::t_out  o_item;
    logic  i_cfg_wr_en;
    logic [sbcd_pkg::RADIUS_W-1:0] i_cfg_data;

    crossing_scoreboard sb;
    int  send_idle_pct;
    int  stall_pct;
    longint cycles;

    sphere_boundary_crossing_detect_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_item(i_item),
        .o_valid(o_valid), .i_stall(i_stall), .o_item(o_item),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_item = '0;
        i_stall = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_data = '0;
        send_idle_pct = 0;
        stall_pct = 0;
        cycles = 0;
        sb = new();
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
        if (i_rst_n) begin
            if (o_valid && !i_stall) sb.check_result(o_item);
            if (i_valid && !o_stall) sb.note_item(i_item);
        end
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic send_item(sbcd_pkg::t_in it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic write_radius(logic [31:0] r);
        drain();
        i_cfg_wr_en <= 1'b1;
        i_cfg_data <= r;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.radius = r;
        @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] rand_coord(int scale);
        case ($urandom_range(3))
            0: return $urandom;
            1: return $signed($urandom_range(2 * scale)) - scale;
            2: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
            default: return $signed($urandom_range(scale));
        endcase
    endfunction

    function automatic sbcd_pkg::t_in vec_at(logic signed [31:0] bx, logic signed [31:0] by,
                                             logic signed [31:0] bz, logic signed [31:0] ax,
                                             logic signed [31:0] ay, logic signed [31:0] az);
        sbcd_pkg::t_in it;
        it.before_x = bx; it.before_y = by; it.before_z = bz;
        it.after_x = ax; it.after_y = ay; it.after_z = az;
        return it;
    endfunction

    // Items that mostly straddle the radius, with some fully random noise.
    function automatic sbcd_pkg::t_in rand_item(logic [31:0] r);
        sbcd_pkg::t_in it;
        int unsigned sc;
        logic signed [31:0] d0, d1;
        if ($urandom_range(9) < 2) begin
            it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            return it;
        end
        sc = (r > 32'h3fff_ffff) ? 32'h3fff_ffff : r;
        d0 = $urandom_range(sc);
        d1 = $signed({1'b0, r[31:1]}) + $signed($urandom_range(sc));
        if ($urandom_range(1)) it = vec_at(d0, rand_coord(8), rand_coord(8),
                                          -d1, rand_coord(8), rand_coord(8));
        else it = vec_at(rand_coord(8), -d1, rand_coord(8),
                         rand_coord(8), d0, rand_coord(8));
        if ($urandom_range(5) == 0) it = vec_at(rand_coord(sc), rand_coord(sc),
                                                rand_coord(sc), rand_coord(sc),
                                                rand_coord(sc), rand_coord(sc));
        return it;
    endfunction

    logic [31:0] radii[6] = '{32'd1, 32'hffff_ffff, 32'd1000, 32'd7, 32'h8000_0000, 32'd65536};

    initial begin
        logic [31:0] r;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // radius left at reset: malformed
        send_item(vec_at(0, 0, 0, 2000, 0, 0));
        send_item(vec_at(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
        write_radius(32'd1000);
        send_item(vec_at(0, 0, 0, 2000, 0, 0));
        send_item(vec_at(2000, 0, 0, 0, 0, 0));
        send_item(vec_at(999, 0, 0, 1001, 0, 0));
        send_item(vec_at(1000, 0, 0, 2000, 0, 0));
        send_item(vec_at(0, 0, 0, 1000, 0, 0));
        send_item(vec_at(10, 0, 0, 20, 0, 0));
        send_item(vec_at(3000, 0, 0, 4000, 0, 0));
        send_item(vec_at(0, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_item(vec_at(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, -1, 1));
        send_item(vec_at(-600, -800, 0, 0, 0, -1001));
        send_item(vec_at(999, 0, 0, 32'h7fff_ffff, 0, 0));
        write_radius(32'd0);
        send_item(vec_at(1, 2, 3, 4, 5, 6));
        write_radius(32'hffff_ffff);
        send_item(vec_at(0, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_item(vec_at(32'h8000_0000, 32'h8000_0000, 0, 1, 1, 1));
        send_item(vec_at(32'h7fff_ffff, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 0));

        for (int ph = 0; ph < 12; ph++) begin
            r = radii[ph % 6];
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 52; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 52; end
                default: begin send_idle_pct = 35; stall_pct = 35; end
            endcase
            write_radius(ph == 11 ? 32'd0 : r);
            for (int k = 0; k < 110; k++) begin
                if (k == 55) drain();
                send_item(rand_item(r));
            end
        end

        send_idle_pct = 0;
        stall_pct = 0;
        drain();
        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end
endmodule

>>> files.f
sv/sbcd_pkg.sv
sv/sbcd_isqrt.sv
sv/sbcd_len.sv
sv/sbcd_frac.sv
sv/sphere_boundary_crossing_detect_unit.sv
bench/testbench.sv
